### hw/rtl/lca_pkg.sv
// Shared types and codes for the LRU core allocator.
package lca_pkg;

    // Default core count and fixed field widths
    localparam int NUM_CORES_DEF = 4;
    localparam int CORE_W        = 2;
    localparam int OWNER_W       = 8;
    localparam int ADDR_W        = 3;
    localparam int WORD_W        = 32;
    localparam int MASK_W        = 4;
    localparam int STATUS_W      = 2;
    localparam int SPLIT_CORES   = 2;

    // Request codes
    localparam logic [1:0] REQ_ALLOC   = 2'd0;
    localparam logic [1:0] REQ_CLOSE   = 2'd1;
    localparam logic [1:0] REQ_RELEASE = 2'd2;

    // Status codes
    localparam logic [STATUS_W-1:0] ST_DONE     = 2'd0;
    localparam logic [STATUS_W-1:0] ST_NO_FREE  = 2'd1;
    localparam logic [STATUS_W-1:0] ST_NO_MATCH = 2'd2;

    // Command to one core cell
    typedef struct packed {
        logic               grant;
        logic               close_req;
        logic               rel_req;
        logic [OWNER_W-1:0] owner;
    } t_core_cmd;

    // Status from one core cell
    typedef struct packed {
        logic              in_use;
        logic              opened;
        logic              match;
        logic [WORD_W-1:0] cnt;
    } t_core_stat;

endpackage

### hw/rtl/lca_rank_cell.sv
// One slot of the recency list; takes its right neighbor's entry on a shift.
module lca_rank_cell
    import lca_pkg::*;
#(
    parameter int IDX_W = 2,
    parameter logic [IDX_W-1:0] INIT = '0
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_shift,
    input  logic [IDX_W-1:0] i_next,
    output logic [IDX_W-1:0] o_entry
);

    logic [IDX_W-1:0] r_entry;

    // Shift left toward the head when a grant removes this slot or an earlier one
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_entry <= INIT;
        end else if (i_shift) begin
            r_entry <= i_next;
        end
    end

    assign o_entry = r_entry;

endmodule

### hw/rtl/lca_core_cell.sv
// Per-core state: in-use bit, owner tag, open mark and grant counter.
module lca_core_cell
    import lca_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  t_core_cmd  i_cmd,
    output t_core_stat o_stat
);

    logic               r_in_use;
    logic               r_open;
    logic [OWNER_W-1:0] r_tag;
    logic [WORD_W-1:0]  r_cnt;
    logic               match;

    assign match = (r_tag == i_cmd.owner);

    // Apply grant, close or release to this core
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_use <= 1'b0;
            r_open   <= 1'b0;
            r_tag    <= '0;
            r_cnt    <= '0;
        end else if (i_cmd.grant) begin
            r_in_use <= 1'b1;
            r_open   <= 1'b1;
            r_tag    <= i_cmd.owner;
            r_cnt    <= r_cnt + 1'b1;
        end else if (i_cmd.close_req && match) begin
            r_in_use <= 1'b0;
            r_open   <= 1'b0;
        end else if (i_cmd.rel_req && match) begin
            r_in_use <= 1'b0;
            r_tag    <= '0;
        end
    end

    assign o_stat.in_use = r_in_use;
    assign o_stat.opened = r_open;
    assign o_stat.match  = match;
    assign o_stat.cnt    = r_cnt;

endmodule

### hw/rtl/lru_core_allocator_with_remap.sv
// Top level: request sequencer, recency chain, core cells and remap word.
//
// Allocates decoder cores to owners from a recency list. Pulse i_start while
// o_busy is low; the item is latched and o_busy rises. An allocate walks the
// recency chain one slot per cycle until it grants a free core or passes the
// last slot; close and release act in S_EXEC, release on all core cells at
// once and close on the named core only. o_done is high for exactly one cycle
// and cannot be stalled; the result ports hold their values until the next result.
// o_busy falls in the strobe cycle, so the next item may be started then.
// Write core_layout through i_cfg_we/i_cfg_wdata only while the block is idle.
module lru_core_allocator_with_remap
    import lca_pkg::*;
#(
    parameter int NUM_CORES = NUM_CORES_DEF
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_start,
    output logic                o_busy,
    input  logic [1:0]          i_req_type,
    input  logic [OWNER_W-1:0]  i_owner,
    input  logic [CORE_W-1:0]   i_core,
    input  logic [ADDR_W-1:0]   i_read_addr_high,
    input  logic [ADDR_W-1:0]   i_write_addr_high,
    input  logic                i_cfg_we,
    input  logic                i_cfg_wdata,
    output logic                o_done,
    output logic [STATUS_W-1:0] o_status,
    output logic [CORE_W-1:0]   o_granted_core,
    output logic [WORD_W-1:0]   o_control_word,
    output logic [MASK_W-1:0]   o_reset_mask,
    output logic [MASK_W-1:0]   o_open_mask,
    output logic [WORD_W-1:0]   o_grant_count
);

    localparam int IDX_W = $clog2(NUM_CORES);
    localparam logic [IDX_W-1:0] LAST_POS = IDX_W'(NUM_CORES - 1);

    typedef enum logic [3:0] {
        S_IDLE = 4'b0001,
        S_SCAN = 4'b0010,
        S_EXEC = 4'b0100,
        S_FIN  = 4'b1000
    } t_state;

    t_state               r_state;
    logic                 r_layout;
    logic [1:0]           r_req;
    logic [OWNER_W-1:0]   r_owner;
    logic [CORE_W-1:0]    r_core;
    logic [ADDR_W-1:0]    r_rd;
    logic [ADDR_W-1:0]    r_wr;
    logic [IDX_W-1:0]     r_pos;
    logic [STATUS_W-1:0]  r_status;
    logic [CORE_W-1:0]    r_grant;
    logic [MASK_W-1:0]    r_rmask;
    logic [WORD_W-1:0]    r_gcount;
    logic [WORD_W-1:0]    r_remap;
    logic                 r_done;
    logic [STATUS_W-1:0]  r_o_status;
    logic [CORE_W-1:0]    r_o_grant;
    logic [WORD_W-1:0]    r_o_word;
    logic [MASK_W-1:0]    r_o_rmask;
    logic [MASK_W-1:0]    r_o_open;
    logic [WORD_W-1:0]    r_o_gcount;

    logic                 accept;
    logic [IDX_W-1:0]     rank_q   [NUM_CORES];
    t_core_cmd            core_cmd [NUM_CORES];
    t_core_stat           core_st  [NUM_CORES];
    logic [NUM_CORES-1:0] use_vec;
    logic [NUM_CORES-1:0] close_hit;
    logic [NUM_CORES-1:0] rel_hit;
    logic [MASK_W-1:0]    rmask_full;
    logic [MASK_W-1:0]    open_full;
    logic [IDX_W-1:0]     cur_entry;
    logic [CORE_W-1:0]    cur_core;
    logic [CORE_W:0]      act_cores;
    logic                 hit;
    logic                 owner_ok;
    logic [4:0]           sh_wr;
    logic [4:0]           sh_rd;
    logic [WORD_W-1:0]    n_remap;
    logic [STATUS_W-1:0]  n_exec_status;

    assign accept   = i_start && (r_state == S_IDLE);
    assign o_busy   = (r_state != S_IDLE);
    assign owner_ok = (r_owner != '0);

    // Examine the recency slot under the scan pointer
    assign cur_entry = rank_q[r_pos];
    assign cur_core  = CORE_W'(cur_entry);
    assign act_cores = (r_layout && (NUM_CORES > SPLIT_CORES))
                       ? (CORE_W+1)'(SPLIT_CORES) : (CORE_W+1)'(NUM_CORES);
    assign hit = (r_state == S_SCAN) && ({1'b0, cur_core} < act_cores)
                 && !use_vec[cur_entry];

    // Recency chain: slots at and after the granted one shift toward the head
    for (genvar i = 0; i < NUM_CORES; i++) begin : g_rank
        logic [IDX_W-1:0] next_entry;
        if (i < NUM_CORES - 1) begin : g_mid
            assign next_entry = rank_q[i+1];
        end else begin : g_tail
            assign next_entry = cur_entry;
        end
        lca_rank_cell #(
            .IDX_W (IDX_W),
            .INIT  (IDX_W'(i))
        ) u_rank (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_shift (hit && (IDX_W'(i) >= r_pos)),
            .i_next  (next_entry),
            .o_entry (rank_q[i])
        );
    end

    // Core cells with their commands
    for (genvar c = 0; c < NUM_CORES; c++) begin : g_core
        assign core_cmd[c].grant     = hit && (cur_entry == IDX_W'(c));
        assign core_cmd[c].close_req = (r_state == S_EXEC) && (r_req == REQ_CLOSE)
                                       && owner_ok && (r_core == CORE_W'(c));
        assign core_cmd[c].rel_req   = (r_state == S_EXEC) && (r_req == REQ_RELEASE)
                                       && owner_ok;
        assign core_cmd[c].owner     = r_owner;
        lca_core_cell u_core (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_cmd   (core_cmd[c]),
            .o_stat  (core_st[c])
        );
        assign use_vec[c]   = core_st[c].in_use;
        assign close_hit[c] = core_st[c].match && (r_core == CORE_W'(c));
        assign rel_hit[c]   = core_st[c].match;
    end

    // Widen per-core bits to the 4-bit result masks
    for (genvar m = 0; m < MASK_W; m++) begin : g_mask
        if (m < NUM_CORES) begin : g_live
            assign rmask_full[m] = core_st[m].match && core_st[m].in_use;
            assign open_full[m]  = core_st[m].opened;
        end else begin : g_none
            assign rmask_full[m] = 1'b0;
            assign open_full[m]  = 1'b0;
        end
    end

    // Status of a close or release
    always_comb begin
        n_exec_status = ST_NO_MATCH;
        if (owner_ok) begin
            if ((r_req == REQ_CLOSE) && (|close_hit)) begin
                n_exec_status = ST_DONE;
            end else if ((r_req == REQ_RELEASE) && (|rel_hit)) begin
                n_exec_status = ST_DONE;
            end
        end
    end

    // Place the address fields of the granted core in the remap word
    always_comb begin
        if (r_layout) begin
            sh_wr = {cur_core[0], 4'b0000};
        end else begin
            sh_wr = {cur_core, 3'b000};
        end
        sh_rd   = sh_wr + 5'd4;
        n_remap = r_remap & ~(WORD_W'(7) << sh_wr) & ~(WORD_W'(7) << sh_rd);
        n_remap = n_remap | (WORD_W'(r_rd) << sh_rd) | (WORD_W'(r_wr) << sh_wr);
    end

    // Configuration register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_layout <= 1'b0;
        end else if (i_cfg_we) begin
            r_layout <= i_cfg_wdata;
        end
    end

    // Sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_remap <= '0;
            r_done  <= 1'b0;
            r_pos   <= '0;
        end else begin
            r_done <= 1'b0;
            case (r_state)
                S_IDLE: begin
                    if (accept) begin
                        r_req    <= i_req_type;
                        r_owner  <= i_owner;
                        r_core   <= i_core;
                        r_rd     <= i_read_addr_high;
                        r_wr     <= i_write_addr_high;
                        r_pos    <= '0;
                        r_grant  <= '0;
                        r_gcount <= '0;
                        r_rmask  <= '0;
                        if (i_req_type == REQ_ALLOC) begin
                            r_status <= ST_NO_FREE;
                            r_state  <= S_SCAN;
                        end else begin
                            r_state  <= S_EXEC;
                        end
                    end
                end
                S_SCAN: begin
                    if (hit) begin
                        r_status <= ST_DONE;
                        r_grant  <= cur_core;
                        r_gcount <= core_st[cur_entry].cnt + 1'b1;
                        r_remap  <= n_remap;
                        r_state  <= S_FIN;
                    end else if (r_pos == LAST_POS) begin
                        r_state  <= S_FIN;
                    end else begin
                        r_pos    <= r_pos + 1'b1;
                    end
                end
                S_EXEC: begin
                    r_status <= n_exec_status;
                    if ((r_req == REQ_RELEASE) && owner_ok) begin
                        r_rmask <= rmask_full;
                    end
                    r_state  <= S_FIN;
                end
                S_FIN: begin
                    r_done  <= 1'b1;
                    r_state <= S_IDLE;
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    // Result registers, loaded once the state has settled
    always_ff @(posedge i_clk) begin
        if (r_state == S_FIN) begin
            r_o_status <= r_status;
            r_o_grant  <= r_grant;
            r_o_word   <= r_remap;
            r_o_rmask  <= r_rmask;
            r_o_open   <= open_full;
            r_o_gcount <= r_gcount;
        end
    end

    assign o_done         = r_done;
    assign o_status       = r_o_status;
    assign o_granted_core = r_o_grant;
    assign o_control_word = r_o_word;
    assign o_reset_mask   = r_o_rmask;
    assign o_open_mask    = r_o_open;
    assign o_grant_count  = r_o_gcount;

    // A result only follows a busy cycle
    a_done_after_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> $past(o_busy))
        else $error("result strobe without a pending item");

    // Failed requests carry no grant
    a_fail_no_grant: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && (o_status != ST_DONE)) |-> ((o_grant_count == '0)
        && (o_granted_core == '0) && (o_reset_mask == '0)))
        else $error("grant or reset reported on a failed request");

    // A grant marks its core open and counts at least once
    a_grant_open: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && (o_status == ST_DONE) && (o_grant_count != '0))
        |-> o_open_mask[o_granted_core])
        else $error("granted core not marked open");

endmodule

### dv/lca_checker.sv
// Result checker for the LRU core allocator: tracks items, predicts and compares results.
module lca_checker
    import lca_pkg::*;
#(
    parameter int NUM_CORES = NUM_CORES_DEF
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_start,
    input  logic                i_busy,
    input  logic [1:0]          i_req_type,
    input  logic [OWNER_W-1:0]  i_owner,
    input  logic [CORE_W-1:0]   i_core,
    input  logic [ADDR_W-1:0]   i_read_addr_high,
    input  logic [ADDR_W-1:0]   i_write_addr_high,
    input  logic                i_cfg_we,
    input  logic                i_cfg_wdata,
    input  logic                i_done,
    input  logic [STATUS_W-1:0] i_status,
    input  logic [CORE_W-1:0]   i_granted_core,
    input  logic [WORD_W-1:0]   i_control_word,
    input  logic [MASK_W-1:0]   i_reset_mask,
    input  logic [MASK_W-1:0]   i_open_mask,
    input  logic [WORD_W-1:0]   i_grant_count,
    output int                  o_fail_count,
    output int                  o_pending
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [CORE_W-1:0]   core;
        logic [WORD_W-1:0]   word;
        logic [MASK_W-1:0]   reset_mask;
        logic [MASK_W-1:0]   open_mask;
        logic [WORD_W-1:0]   count;
    } t_alloc_result;

    // Shadow of the allocator state
    logic [CORE_W-1:0]  lru_order [NUM_CORES];
    logic               core_busy [NUM_CORES];
    logic [OWNER_W-1:0] core_owner [NUM_CORES];
    logic               core_open [NUM_CORES];
    logic [WORD_W-1:0]  core_grants [NUM_CORES];
    logic [WORD_W-1:0]  remap_word;
    logic               two_core_layout;

    t_alloc_result      expected_results [$];
    t_alloc_result      want;
    int                 fails = 0;
    int                 results_seen = 0;

    // Return the allocator to its power-up state
    function automatic void clear_state();
        int c;
        for (c = 0; c < NUM_CORES; c++) begin
            lru_order[c]   = CORE_W'(c);
            core_busy[c]   = 1'b0;
            core_owner[c]  = '0;
            core_open[c]   = 1'b0;
            core_grants[c] = '0;
        end
        remap_word      = '0;
        two_core_layout = 1'b0;
    endfunction

    // Place a granted core's address-high fields into the remap word
    function automatic void place_fields(int c, logic [ADDR_W-1:0] rd, logic [ADDR_W-1:0] wr);
        int stride;
        int wr_pos;
        int rd_pos;
        stride = two_core_layout ? 16 : 8;
        wr_pos = (c * stride) % 32;
        rd_pos = (wr_pos + 4) % 32;
        remap_word &= ~(32'd7 << wr_pos);
        remap_word &= ~(32'd7 << rd_pos);
        remap_word |= WORD_W'(rd) << rd_pos;
        remap_word |= WORD_W'(wr) << wr_pos;
    endfunction

    // Apply one request to the shadow state and form its result
    function automatic t_alloc_result serve_request(logic [1:0] req, logic [OWNER_W-1:0] owner,
                                                    logic [CORE_W-1:0] core,
                                                    logic [ADDR_W-1:0] rd,
                                                    logic [ADDR_W-1:0] wr);
        t_alloc_result r;
        int            active;
        int            p;
        int            q;
        int            c;
        bit            found;
        r        = '0;
        r.status = ST_NO_MATCH;
        found    = 1'b0;
        case (req)
            REQ_ALLOC: begin
                active   = two_core_layout ? SPLIT_CORES : NUM_CORES;
                r.status = ST_NO_FREE;
                for (p = 0; p < NUM_CORES; p++) begin
                    c = int'(lru_order[p]);
                    if (!found && c < active && !core_busy[c]) begin
                        found          = 1'b1;
                        core_busy[c]   = 1'b1;
                        core_owner[c]  = owner;
                        core_open[c]   = 1'b1;
                        core_grants[c] = core_grants[c] + 1;
                        place_fields(c, rd, wr);
                        // move the granted core to the tail of the list
                        for (q = p; q < NUM_CORES - 1; q++)
                            lru_order[q] = lru_order[q + 1];
                        lru_order[NUM_CORES - 1] = CORE_W'(c);
                        r.status = ST_DONE;
                        r.core   = CORE_W'(c);
                        r.count  = core_grants[c];
                    end
                end
            end
            REQ_CLOSE: begin
                if (owner != '0 && int'(core) < NUM_CORES && core_owner[core] == owner) begin
                    core_busy[core] = 1'b0;
                    core_open[core] = 1'b0;
                    r.status        = ST_DONE;
                end
            end
            REQ_RELEASE: begin
                if (owner != '0) begin
                    for (c = 0; c < NUM_CORES; c++) begin
                        if (core_owner[c] == owner) begin
                            if (core_busy[c]) begin
                                core_busy[c]     = 1'b0;
                                r.reset_mask[c]  = 1'b1;
                            end
                            core_owner[c] = '0;
                            r.status      = ST_DONE;
                        end
                    end
                end
            end
            default: ;
        endcase
        r.word = remap_word;
        for (c = 0; c < NUM_CORES && c < MASK_W; c++)
            r.open_mask[c] = core_open[c];
        return r;
    endfunction

    // Print a mismatch line (for the first 50 only) and count it
    task automatic report(string what, logic [WORD_W-1:0] got, logic [WORD_W-1:0] exp_v);
        if (fails < 50)
            $display("MISMATCH result %0d %s: got 0x%0h, want 0x%0h",
                     results_seen, what, got, exp_v);
        fails++;
    endtask

    // Compare the outgoing result first, then log config writes and new items
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            clear_state();
            expected_results.delete();
        end else begin
            if (i_done) begin
                if (expected_results.size() == 0) begin
                    report("result with no item pending", i_control_word, '0);
                end else begin
                    want = expected_results.pop_front();
                    if (i_status !== want.status)
                        report("status", i_status, want.status);
                    if (i_granted_core !== want.core)
                        report("granted_core", i_granted_core, want.core);
                    if (i_control_word !== want.word)
                        report("control_word", i_control_word, want.word);
                    if (i_reset_mask !== want.reset_mask)
                        report("reset_mask", i_reset_mask, want.reset_mask);
                    if (i_open_mask !== want.open_mask)
                        report("open_mask", i_open_mask, want.open_mask);
                    if (i_grant_count !== want.count)
                        report("grant_count", i_grant_count, want.count);
                end
                results_seen++;
            end
            if (i_cfg_we)
                two_core_layout = i_cfg_wdata;
            if (i_start && !i_busy)
                expected_results.push_back(serve_request(i_req_type, i_owner, i_core,
                                                         i_read_addr_high,
                                                         i_write_addr_high));
        end
        o_pending    <= expected_results.size();
        o_fail_count <= fails;
    end

endmodule

### dv/tb_lru_core_allocator_with_remap.sv
// Testbench top for the LRU core allocator: stimulus, config phases and verdict.
module tb_lru_core_allocator_with_remap;
    timeunit 1ns;
    timeprecision 1ps;
    import lca_pkg::*;

    localparam int         NUM_CORES     = NUM_CORES_DEF;
    localparam logic [1:0] REQ_RESERVED  = 2'd3;
    localparam int         SETTLE_CYCLES = NUM_CORES + 4;
    localparam int         CYCLE_LIMIT   = 200000;

    logic                i_clk             = 1'b0;
    logic                i_rst_n           = 1'b0;
    logic                i_start           = 1'b0;
    logic [1:0]          i_req_type        = '0;
    logic [OWNER_W-1:0]  i_owner           = '0;
    logic [CORE_W-1:0]   i_core            = '0;
    logic [ADDR_W-1:0]   i_read_addr_high  = '0;
    logic [ADDR_W-1:0]   i_write_addr_high = '0;
    logic                i_cfg_we          = 1'b0;
    logic                i_cfg_wdata       = 1'b0;
    logic                o_busy;
    logic                o_done;
    logic [STATUS_W-1:0] o_status;
    logic [CORE_W-1:0]   o_granted_core;
    logic [WORD_W-1:0]   o_control_word;
    logic [MASK_W-1:0]   o_reset_mask;
    logic [MASK_W-1:0]   o_open_mask;
    logic [WORD_W-1:0]   o_grant_count;

    int                  fail_count;
    int                  pending;
    int                  idle_pct = 0;
    int                  cycle_cnt = 0;
    logic [OWNER_W-1:0]  owner_pool [4];

    lru_core_allocator_with_remap #(.NUM_CORES(NUM_CORES)) uut (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_start           (i_start),
        .o_busy            (o_busy),
        .i_req_type        (i_req_type),
        .i_owner           (i_owner),
        .i_core            (i_core),
        .i_read_addr_high  (i_read_addr_high),
        .i_write_addr_high (i_write_addr_high),
        .i_cfg_we          (i_cfg_we),
        .i_cfg_wdata       (i_cfg_wdata),
        .o_done            (o_done),
        .o_status          (o_status),
        .o_granted_core    (o_granted_core),
        .o_control_word    (o_control_word),
        .o_reset_mask      (o_reset_mask),
        .o_open_mask       (o_open_mask),
        .o_grant_count     (o_grant_count)
    );

    lca_checker #(.NUM_CORES(NUM_CORES)) u_checker (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_start           (i_start),
        .i_busy            (o_busy),
        .i_req_type        (i_req_type),
        .i_owner           (i_owner),
        .i_core            (i_core),
        .i_read_addr_high  (i_read_addr_high),
        .i_write_addr_high (i_write_addr_high),
        .i_cfg_we          (i_cfg_we),
        .i_cfg_wdata       (i_cfg_wdata),
        .i_done            (o_done),
        .i_status          (o_status),
        .i_granted_core    (o_granted_core),
        .i_control_word    (o_control_word),
        .i_reset_mask      (o_reset_mask),
        .i_open_mask       (o_open_mask),
        .i_grant_count     (o_grant_count),
        .o_fail_count      (fail_count),
        .o_pending         (pending)
    );

    // 20 ns clock
    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    // Abort a hung run
    always @(posedge i_clk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt == CYCLE_LIMIT) begin
            $display("Verification failed");
            $finish;
        end
    end

    // Offer one item after a random gap and hold it until accepted; start stays high
    task automatic send_item(logic [1:0] req, logic [OWNER_W-1:0] owner,
                             logic [CORE_W-1:0] core, logic [ADDR_W-1:0] rd,
                             logic [ADDR_W-1:0] wr);
        while ($urandom_range(99) < idle_pct) begin
            i_start <= 1'b0;
            @(posedge i_clk);
        end
        i_start           <= 1'b1;
        i_req_type        <= req;
        i_owner           <= owner;
        i_core            <= core;
        i_read_addr_high  <= rd;
        i_write_addr_high <= wr;
        do
            @(posedge i_clk);
        while (o_busy);
    endtask

    // Drop start and wait until every item has answered
    task automatic settle();
        i_start <= 1'b0;
        @(posedge i_clk);
        while (pending != 0)
            @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_layout(logic two_cores);
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= two_cores;
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
    endtask

    // Mostly pool owners so closes and releases hit; some reserved and noise items
    task automatic random_item();
        int                 pick;
        logic [1:0]         req;
        logic [OWNER_W-1:0] who;
        pick = $urandom_range(99);
        who  = owner_pool[$urandom_range(3)];
        if (pick < 45)
            req = REQ_ALLOC;
        else if (pick < 75)
            req = REQ_CLOSE;
        else if (pick < 88)
            req = REQ_RELEASE;
        else if (pick < 93)
            req = REQ_RESERVED;
        else begin
            req = 2'($urandom_range(3));
            who = OWNER_W'($urandom_range(255, 1));
        end
        send_item(req, who, CORE_W'($urandom_range(3)), ADDR_W'($urandom_range(7)),
                  ADDR_W'($urandom_range(7)));
    endtask

    task automatic run_phase(int count, int gap_pct, logic two_cores);
        int n;
        settle();
        write_layout(two_cores);
        idle_pct      = gap_pct;
        owner_pool[0] = 8'h01;
        owner_pool[1] = 8'hFF;
        owner_pool[2] = OWNER_W'($urandom_range(255, 1));
        owner_pool[3] = OWNER_W'($urandom_range(255, 1));
        for (n = 0; n < count; n++)
            random_item();
    endtask

    initial begin
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        write_layout(1'b0);

        // Four-core layout: fill every core, then run out
        send_item(REQ_ALLOC, 8'h01, 2'd0, 3'd7, 3'd0);
        send_item(REQ_ALLOC, 8'hFF, 2'd0, 3'd0, 3'd7);
        send_item(REQ_ALLOC, 8'h5A, 2'd0, 3'd5, 3'd2);
        send_item(REQ_ALLOC, 8'h01, 2'd0, 3'd7, 3'd7);
        send_item(REQ_ALLOC, 8'hFF, 2'd3, 3'd1, 3'd1);
        // Wrong owner, matching close, repeated close
        send_item(REQ_CLOSE, 8'h01, 2'd1, 3'd0, 3'd0);
        send_item(REQ_CLOSE, 8'hFF, 2'd1, 3'd0, 3'd0);
        send_item(REQ_CLOSE, 8'hFF, 2'd1, 3'd0, 3'd0);
        // Owner zero never matches
        send_item(REQ_CLOSE, 8'h00, 2'd2, 3'd0, 3'd0);
        send_item(REQ_RELEASE, 8'h00, 2'd0, 3'd0, 3'd0);
        // Release frees two cores, then finds nothing
        send_item(REQ_RELEASE, 8'h01, 2'd0, 3'd0, 3'd0);
        send_item(REQ_RELEASE, 8'h01, 2'd0, 3'd0, 3'd0);
        send_item(REQ_RESERVED, 8'h5A, 2'd3, 3'd7, 3'd7);
        send_item(REQ_ALLOC, 8'h5A, 2'd0, 3'd3, 3'd4);
        send_item(REQ_ALLOC, 8'hAA, 2'd0, 3'd6, 3'd1);
        send_item(REQ_RELEASE, 8'hFF, 2'd0, 3'd0, 3'd0);

        // Two-core layout: upper cores are skipped even when free
        settle();
        write_layout(1'b1);
        send_item(REQ_ALLOC, 8'h55, 2'd0, 3'd3, 3'd6);
        send_item(REQ_CLOSE, 8'hAA, 2'd1, 3'd0, 3'd0);
        send_item(REQ_ALLOC, 8'h55, 2'd0, 3'd3, 3'd6);
        send_item(REQ_RELEASE, 8'h5A, 2'd0, 3'd0, 3'd0);
        send_item(REQ_ALLOC, 8'h80, 2'd0, 3'd1, 3'd4);
        send_item(REQ_ALLOC, 8'h7F, 2'd0, 3'd2, 3'd5);
        send_item(REQ_CLOSE, 8'h01, 2'd3, 3'd0, 3'd0);

        run_phase(145, 20, 1'b1);
        run_phase(145, 65, 1'b0);
        run_phase(145, 0, 1'b1);
        settle();

        if (fail_count == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule
